// ===== hw/rtl/rcpa_pkg.sv =====
// Shared constants and codes for the reference-counted pool allocator.
`timescale 1ns / 1ps

package rcpa_pkg;

    // Default pool size
    localparam int DEFAULT_POOL_ENTRIES = 16;

    // Field widths
    localparam int KIND_W       = 2;
    localparam int INDEX_W      = 4;
    localparam int COUNT_W      = 8;
    localparam int STATUS_W     = 2;
    localparam int FREE_W       = 5;
    localparam int IN_TDATA_W   = 8;
    localparam int OUT_TDATA_W  = 24;

    // Count limits
    localparam logic [COUNT_W-1:0] COUNT_MAX  = 8'hFF;
    localparam logic [COUNT_W-1:0] COUNT_ZERO = 8'h00;
    localparam logic [COUNT_W-1:0] COUNT_ONE  = 8'h01;
    localparam logic [FREE_W-1:0]  FREE_SAT   = 5'd31;

    // Request kinds
    localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
    localparam logic [KIND_W-1:0] KIND_INC   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DEC   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_QUERY = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_FREE  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_AT_MAX   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_DEC_ZERO = 2'd3;

endpackage

// ===== hw/rtl/rcpa_count_ram.sv =====
// Reference count memory: one write port, one read port with registered data.
`timescale 1ns / 1ps

module rcpa_count_ram #(
    parameter int DEPTH = rcpa_pkg::DEFAULT_POOL_ENTRIES,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                         clk,
    input  logic                         we,
    input  logic [AW-1:0]                waddr,
    input  logic [rcpa_pkg::COUNT_W-1:0] wdata,
    input  logic                         re,
    input  logic [AW-1:0]                raddr,
    output logic [rcpa_pkg::COUNT_W-1:0] rdata
);

    logic [rcpa_pkg::COUNT_W-1:0] mem [DEPTH];
    logic [rcpa_pkg::COUNT_W-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, data registered
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/rcpa_free_search.sv =====
// Lowest free entry search over the in-use bitmap, result registered.
`timescale 1ns / 1ps

module rcpa_free_search #(
    parameter int ENTRIES = rcpa_pkg::DEFAULT_POOL_ENTRIES,
    parameter int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [ENTRIES-1:0] used,
    output logic               found,
    output logic [AW-1:0]      index
);

    logic          found_reg;
    logic          found_next;
    logic [AW-1:0] index_reg;
    logic [AW-1:0] index_next;

    // Priority pick of the lowest clear bit
    always_comb
    begin
        found_next = 1'b0;
        index_next = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (!used[i])
            begin
                found_next = 1'b1;
                index_next = AW'(i);
            end
        end
    end

    // Hold the pick for the next request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b1;
            index_reg <= '0;
        end
        else
        begin
            found_reg <= found_next;
            index_reg <= index_next;
        end
    end

    assign found = found_reg;
    assign index = index_reg;

endmodule

// ===== hw/rtl/refcounted_pool_allocator.sv =====
// Top level of the reference-counted buffer pool allocator.
// A request is accepted in S_IDLE; its result is registered in S_EXEC once the output register is free.
// A new request is taken only in S_IDLE, after the count memory read-modify-write of the last one.
// A result waiting on m_tready holds the modify step; the next request is still taken.
// Reset clears the in-use bitmap and sets the free count to the pool size; counts read as zero until written.
// The lowest free entry is searched from the bitmap ahead of the request and held in a register.
`timescale 1ns / 1ps

module refcounted_pool_allocator #(
    parameter int POOL_ENTRIES = rcpa_pkg::DEFAULT_POOL_ENTRIES
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [rcpa_pkg::IN_TDATA_W-1:0]  s_tdata,  // [3:0] entry_index, [7:4] zero
    input  logic [rcpa_pkg::KIND_W-1:0]      s_tuser,  // [1:0] kind
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [rcpa_pkg::OUT_TDATA_W-1:0] m_tdata,  // [3:0] result_index, [11:4] ref_count,
                                                       // [12] in_use, [17:13] free_count,
                                                       // [23:18] zero
    output logic [rcpa_pkg::STATUS_W-1:0]    m_tuser   // [1:0] status
);

    localparam int AW  = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
    localparam int FCW = $clog2(POOL_ENTRIES + 1);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t state_reg;

    // Latched request
    logic [rcpa_pkg::KIND_W-1:0]  kind_reg;
    logic [rcpa_pkg::INDEX_W-1:0] idx_reg;
    logic                         in_range_reg;
    logic [AW-1:0]                addr_reg;

    // Pool state in flops
    logic [POOL_ENTRIES-1:0] used_reg;
    logic [POOL_ENTRIES-1:0] used_next;
    logic [FCW-1:0]          free_reg;
    logic [FCW-1:0]          free_next;

    // Output register
    logic                           out_valid_reg;
    logic [rcpa_pkg::STATUS_W-1:0]  out_status_reg;
    logic [rcpa_pkg::STATUS_W-1:0]  out_status_next;
    logic [rcpa_pkg::INDEX_W-1:0]   out_idx_reg;
    logic [rcpa_pkg::INDEX_W-1:0]   out_idx_next;
    logic [rcpa_pkg::COUNT_W-1:0]   out_cnt_reg;
    logic [rcpa_pkg::COUNT_W-1:0]   out_cnt_next;
    logic [rcpa_pkg::FREE_W-1:0]    out_free_reg;
    logic [rcpa_pkg::FREE_W-1:0]    out_free_next;

    // Memory and search wiring
    logic                         mem_we;
    logic [AW-1:0]                mem_waddr;
    logic [rcpa_pkg::COUNT_W-1:0] mem_wdata;
    logic                         mem_re;
    logic [AW-1:0]                in_addr;
    logic [rcpa_pkg::COUNT_W-1:0] mem_rdata;
    logic                         ff_found;
    logic [AW-1:0]                ff_index;

    logic                         in_fire;
    logic                         exec_go;
    logic                         in_range;
    logic [rcpa_pkg::COUNT_W-1:0] cur_cnt;

    rcpa_count_ram #(
        .DEPTH (POOL_ENTRIES),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (in_addr),
        .rdata (mem_rdata)
    );

    rcpa_free_search #(
        .ENTRIES (POOL_ENTRIES),
        .AW      (AW)
    ) u_search (
        .clk   (clk),
        .rst_n (rst_n),
        .used  (used_reg),
        .found (ff_found),
        .index (ff_index)
    );

    // Decode the incoming transaction
    assign s_tready = (state_reg == S_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign in_addr  = AW'(s_tdata[rcpa_pkg::INDEX_W-1:0]);
    assign in_range = (32'(s_tdata[rcpa_pkg::INDEX_W-1:0]) < POOL_ENTRIES);
    assign mem_re   = in_fire;

    // Modify only once the output register can take the result
    assign exec_go = (state_reg == S_EXEC) && (!out_valid_reg || m_tready);

    // Entries not in use read as zero
    assign cur_cnt = used_reg[addr_reg] ? mem_rdata : rcpa_pkg::COUNT_ZERO;

    // Compute the new count, bitmap, free count and result
    always_comb
    begin
        used_next       = used_reg;
        free_next       = free_reg;
        mem_we          = 1'b0;
        mem_waddr       = addr_reg;
        mem_wdata       = cur_cnt;
        out_status_next = rcpa_pkg::ST_OK;
        out_idx_next    = idx_reg;
        out_cnt_next    = rcpa_pkg::COUNT_ZERO;

        if (kind_reg == rcpa_pkg::KIND_ALLOC)
        begin
            if (ff_found)
            begin
                mem_we              = 1'b1;
                mem_waddr           = ff_index;
                mem_wdata           = rcpa_pkg::COUNT_ONE;
                used_next[ff_index] = 1'b1;
                free_next           = free_reg - FCW'(1);
                out_idx_next        = rcpa_pkg::INDEX_W'(ff_index);
                out_cnt_next        = rcpa_pkg::COUNT_ONE;
            end
            else
            begin
                out_status_next = rcpa_pkg::ST_NO_FREE;
                out_idx_next    = '0;
            end
        end
        else if (in_range_reg)
        begin
            mem_we       = 1'b1;
            out_cnt_next = cur_cnt;
            unique case (kind_reg)
                rcpa_pkg::KIND_INC:
                begin
                    if (cur_cnt == rcpa_pkg::COUNT_MAX)
                    begin
                        out_status_next = rcpa_pkg::ST_AT_MAX;
                    end
                    else
                    begin
                        mem_wdata           = cur_cnt + rcpa_pkg::COUNT_ONE;
                        out_cnt_next        = cur_cnt + rcpa_pkg::COUNT_ONE;
                        used_next[addr_reg] = 1'b1;
                        if (cur_cnt == rcpa_pkg::COUNT_ZERO)
                        begin
                            free_next = free_reg - FCW'(1);
                        end
                    end
                end
                rcpa_pkg::KIND_DEC:
                begin
                    if (cur_cnt == rcpa_pkg::COUNT_ZERO)
                    begin
                        out_status_next = rcpa_pkg::ST_DEC_ZERO;
                    end
                    else
                    begin
                        mem_wdata    = cur_cnt - rcpa_pkg::COUNT_ONE;
                        out_cnt_next = cur_cnt - rcpa_pkg::COUNT_ONE;
                        if (cur_cnt == rcpa_pkg::COUNT_ONE)
                        begin
                            used_next[addr_reg] = 1'b0;
                            free_next           = free_reg + FCW'(1);
                        end
                    end
                end
                default:
                begin
                    // query: write back the same count
                    mem_wdata = cur_cnt;
                end
            endcase
        end

        // Saturate the free count to the field width
        if (32'(free_next) > 32'(rcpa_pkg::FREE_SAT))
        begin
            out_free_next = rcpa_pkg::FREE_SAT;
        end
        else
        begin
            out_free_next = rcpa_pkg::FREE_W'(free_next);
        end

        if (!exec_go)
        begin
            mem_we    = 1'b0;
            used_next = used_reg;
            free_next = free_reg;
        end
    end

    // Hold state, pool flags, the output valid and the result payload
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            used_reg       <= '0;
            free_reg       <= FCW'(POOL_ENTRIES);
            out_valid_reg  <= 1'b0;
            out_status_reg <= rcpa_pkg::ST_OK;
            out_idx_reg    <= '0;
            out_cnt_reg    <= rcpa_pkg::COUNT_ZERO;
            out_free_reg   <= '0;
        end
        else
        begin
            used_reg <= used_next;
            free_reg <= free_next;
            if (exec_go)
            begin
                out_status_reg <= out_status_next;
                out_idx_reg    <= out_idx_next;
                out_cnt_reg    <= out_cnt_next;
                out_free_reg   <= out_free_next;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        state_reg <= S_EXEC;
                    end
                    if (m_tready)
                    begin
                        out_valid_reg <= 1'b0;
                    end
                end
                S_EXEC:
                begin
                    if (exec_go)
                    begin
                        state_reg     <= S_IDLE;
                        out_valid_reg <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Latch the request payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            kind_reg     <= s_tuser;
            idx_reg      <= s_tdata[rcpa_pkg::INDEX_W-1:0];
            in_range_reg <= in_range;
            addr_reg     <= in_addr;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {6'b0, out_free_reg, (out_cnt_reg != rcpa_pkg::COUNT_ZERO),
                       out_cnt_reg, out_idx_reg};

    // Free count tracks the bitmap
    a_free_matches: assert property (@(posedge clk) disable iff (!rst_n)
        (32'($countones(used_reg)) + 32'(free_reg)) == POOL_ENTRIES)
        else $error("free count disagrees with in-use bitmap");

    // A full pool reports no free entries
    a_no_free_full: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == rcpa_pkg::ST_NO_FREE) |-> (m_tdata[17:13] == '0))
        else $error("no-free status with free entries left");

    // Saturated increment reports the maximum count
    a_at_max_count: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == rcpa_pkg::ST_AT_MAX) |-> (m_tdata[11:4] == rcpa_pkg::COUNT_MAX))
        else $error("at-max status without maximum count");

    // Bitmap changes only on the modify step
    a_bitmap_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(exec_go) |-> $stable(used_reg))
        else $error("in-use bitmap changed outside a modify step");

endmodule
